// ===== design/smcr_pkg.sv =====
// smcr_pkg: shared types and constants for the scaled mask color remap blit
// no dependencies; imported by the interfaces and every module of the block
package smcr_pkg;

    localparam int PIX_W      = 16;
    localparam int OFS_W      = 25;
    localparam int DIM_W      = 12;
    localparam int STEP_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 32;
    localparam int IDX_W      = 16;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int REQ_W      = 2;

    localparam logic [STEP_W-1:0] STEP_ONE = 24'h010000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_WIDTH  = 3'd0,
        CFG_RECT_HEIGHT = 3'd1,
        CFG_X_STEP      = 3'd2,
        CFG_Y_STEP      = 3'd3,
        CFG_MASK_PITCH  = 3'd4,
        CFG_DEST_PITCH  = 3'd5,
        CFG_DEST_X      = 3'd6,
        CFG_DEST_Y      = 3'd7
    } cfg_index_e;

    typedef enum logic [REQ_W-1:0] {
        REQ_MASK  = 2'd0,
        REQ_REMAP = 2'd1,
        REQ_PIXEL = 2'd2
    } req_type_e;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [IDX_W-1:0] table_index;
        logic [PIX_W-1:0] table_value;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [OFS_W-1:0] dest_offset;
        logic [PIX_W-1:0] pixel_out;
        logic             last_pixel;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]  rect_width;
        logic [DIM_W-1:0]  rect_height;
        logic [STEP_W-1:0] x_step;
        logic [STEP_W-1:0] y_step;
        logic [DIM_W-1:0]  mask_pitch;
        logic [DIM_W-1:0]  dest_pitch;
        logic [OFS_W-1:0]  start_base;
    } cfg_t;

    typedef struct packed {
        logic [OFS_W-1:0] ofs;
        logic             last;
    } walk_info_t;

    typedef struct packed {
        logic wr_mask;
        logic wr_remap;
        logic rd;
    } lookup_ctl_t;

    typedef struct packed {
        logic [OFS_W-1:0]  ofs;
        logic              last;
        logic [MASK_W-1:0] mask_byte;
        logic [PIX_W-1:0]  pixel;
        logic [PIX_W-1:0]  remap;
    } lookup_t;

endpackage

// ===== design/smcr_req_if.sv =====
// smcr_req_if: request channel carrying write and pixel transactions
// depends on smcr_pkg for the payload type
interface smcr_req_if;
    import smcr_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/smcr_rsp_if.sv =====
// smcr_rsp_if: result channel carrying one transaction per processed pixel
// depends on smcr_pkg for the payload type
interface smcr_rsp_if;
    import smcr_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/smcr_cfg_regs.sv =====
// smcr_cfg_regs: configuration register file plus the registered rectangle start offset
// depends on smcr_pkg
module smcr_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [smcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [smcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output smcr_pkg::cfg_t                    cfg
);
    import smcr_pkg::*;

    logic [DIM_W-1:0]  rect_width_reg, rect_width_next;
    logic [DIM_W-1:0]  rect_height_reg, rect_height_next;
    logic [STEP_W-1:0] x_step_reg, x_step_next;
    logic [STEP_W-1:0] y_step_reg, y_step_next;
    logic [DIM_W-1:0]  mask_pitch_reg, mask_pitch_next;
    logic [DIM_W-1:0]  dest_pitch_reg, dest_pitch_next;
    logic [DIM_W-1:0]  dest_x_reg, dest_x_next;
    logic [DIM_W-1:0]  dest_y_reg, dest_y_next;
    logic [OFS_W-1:0]  start_base_reg, start_base_next;
    logic [2*DIM_W-1:0] row_prod;

    always_comb
    begin
        rect_width_next  = rect_width_reg;
        rect_height_next = rect_height_reg;
        x_step_next      = x_step_reg;
        y_step_next      = y_step_reg;
        mask_pitch_next  = mask_pitch_reg;
        dest_pitch_next  = dest_pitch_reg;
        dest_x_next      = dest_x_reg;
        dest_y_next      = dest_y_reg;
        if (cfg_we)
        begin
            case (cfg_index_e'(cfg_index))
                CFG_RECT_WIDTH:  rect_width_next  = cfg_data[DIM_W-1:0];
                CFG_RECT_HEIGHT: rect_height_next = cfg_data[DIM_W-1:0];
                CFG_X_STEP:      x_step_next      = cfg_data[STEP_W-1:0];
                CFG_Y_STEP:      y_step_next      = cfg_data[STEP_W-1:0];
                CFG_MASK_PITCH:  mask_pitch_next  = cfg_data[DIM_W-1:0];
                CFG_DEST_PITCH:  dest_pitch_next  = cfg_data[DIM_W-1:0];
                CFG_DEST_X:      dest_x_next      = cfg_data[DIM_W-1:0];
                CFG_DEST_Y:      dest_y_next      = cfg_data[DIM_W-1:0];
                default:         rect_width_next  = rect_width_reg;
            endcase
        end
    end

    // top-left offset of the rectangle, registered from the stored destination x, y and pitch
    always_comb
    begin
        row_prod        = (2*DIM_W)'(dest_y_reg) * (2*DIM_W)'(dest_pitch_reg);
        start_base_next = OFS_W'(row_prod) + OFS_W'(dest_x_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
            x_step_reg      <= STEP_ONE;
            y_step_reg      <= STEP_ONE;
            mask_pitch_reg  <= '0;
            dest_pitch_reg  <= '0;
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            start_base_reg  <= '0;
        end
        else
        begin
            rect_width_reg  <= rect_width_next;
            rect_height_reg <= rect_height_next;
            x_step_reg      <= x_step_next;
            y_step_reg      <= y_step_next;
            mask_pitch_reg  <= mask_pitch_next;
            dest_pitch_reg  <= dest_pitch_next;
            dest_x_reg      <= dest_x_next;
            dest_y_reg      <= dest_y_next;
            start_base_reg  <= start_base_next;
        end
    end

    assign cfg.rect_width  = rect_width_reg;
    assign cfg.rect_height = rect_height_reg;
    assign cfg.x_step      = x_step_reg;
    assign cfg.y_step      = y_step_reg;
    assign cfg.mask_pitch  = mask_pitch_reg;
    assign cfg.dest_pitch  = dest_pitch_reg;
    assign cfg.start_base  = start_base_reg;
endmodule

// ===== design/smcr_walk.sv =====
// smcr_walk: raster walk state, mask sample address and destination offset per pixel
// depends on smcr_pkg
module smcr_walk #(
    parameter int MASK_AW = 12
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  smcr_pkg::cfg_t         cfg,
    input  logic                   restart,
    input  logic                   step,
    output logic [MASK_AW-1:0]     mask_addr,
    output smcr_pkg::walk_info_t   info
);
    import smcr_pkg::*;

    localparam int YSUM_W  = STEP_W + 1;
    localparam int CARRY_W = YSUM_W - FRAC_W;
    localparam int PROD_W  = CARRY_W + DIM_W;

    logic [DIM_W-1:0]   col_reg, col_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic [ACC_W-1:0]   x_accum_reg, x_accum_next;
    logic [FRAC_W-1:0]  y_frac_reg, y_frac_next;
    logic [MASK_AW-1:0] mask_base_reg, mask_base_next;
    logic [OFS_W-1:0]   dest_base_reg, dest_base_next;

    logic               first;
    logic [OFS_W-1:0]   drb;
    logic [MASK_AW-1:0] mrb;
    logic [ACC_W-1:0]   xa;
    logic [FRAC_W-1:0]  yf;
    logic [DIM_W:0]     col_inc;
    logic [DIM_W:0]     row_inc;
    logic               row_end;
    logic               rect_end;
    logic [YSUM_W-1:0]  y_sum;
    logic [PROD_W-1:0]  row_adv;

    // first pixel of a rectangle starts from the configured origin
    always_comb
    begin
        first    = (col_reg == '0) && (row_reg == '0);
        drb      = first ? cfg.start_base : dest_base_reg;
        mrb      = first ? '0 : mask_base_reg;
        xa       = first ? '0 : x_accum_reg;
        yf       = first ? '0 : y_frac_reg;
        col_inc  = {1'b0, col_reg} + (DIM_W+1)'(1);
        row_inc  = {1'b0, row_reg} + (DIM_W+1)'(1);
        row_end  = col_inc >= {1'b0, cfg.rect_width};
        rect_end = row_inc >= {1'b0, cfg.rect_height};
        y_sum    = YSUM_W'(yf) + YSUM_W'(cfg.y_step);
        row_adv  = PROD_W'(y_sum[YSUM_W-1:FRAC_W]) * PROD_W'(cfg.mask_pitch);
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        x_accum_next   = x_accum_reg;
        y_frac_next    = y_frac_reg;
        mask_base_next = mask_base_reg;
        dest_base_next = dest_base_reg;
        if (restart)
        begin
            col_next       = '0;
            row_next       = '0;
            x_accum_next   = '0;
            y_frac_next    = '0;
            mask_base_next = '0;
            dest_base_next = '0;
        end
        else if (step)
        begin
            if (row_end && rect_end)
            begin
                col_next       = '0;
                row_next       = '0;
                x_accum_next   = '0;
                y_frac_next    = '0;
                mask_base_next = '0;
                dest_base_next = '0;
            end
            else if (row_end)
            begin
                col_next       = '0;
                row_next       = row_inc[DIM_W-1:0];
                x_accum_next   = '0;
                y_frac_next    = y_sum[FRAC_W-1:0];
                mask_base_next = mrb + row_adv[MASK_AW-1:0];
                dest_base_next = drb + OFS_W'(cfg.dest_pitch);
            end
            else
            begin
                col_next       = col_inc[DIM_W-1:0];
                x_accum_next   = xa + ACC_W'(cfg.x_step);
                y_frac_next    = yf;
                mask_base_next = mrb;
                dest_base_next = drb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            x_accum_reg   <= '0;
            y_frac_reg    <= '0;
            mask_base_reg <= '0;
            dest_base_reg <= '0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            x_accum_reg   <= x_accum_next;
            y_frac_reg    <= y_frac_next;
            mask_base_reg <= mask_base_next;
            dest_base_reg <= dest_base_next;
        end
    end

    assign mask_addr = mrb + MASK_AW'(xa[ACC_W-1:FRAC_W]);
    assign info.ofs  = drb + OFS_W'(col_reg);
    assign info.last = row_end && rect_end;
endmodule

// ===== design/smcr_lookup.sv =====
// smcr_lookup: mask store and remap table memories with registered read data
// depends on smcr_pkg
module smcr_lookup #(
    parameter int MASK_DEPTH = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             clk,
    input  smcr_pkg::lookup_ctl_t            ctl,
    input  smcr_pkg::in_item_t               item,
    input  logic [$clog2(MASK_DEPTH)-1:0]    mask_addr,
    input  smcr_pkg::walk_info_t             info,
    output smcr_pkg::lookup_t                res
);
    import smcr_pkg::*;

    localparam int MASK_AW     = $clog2(MASK_DEPTH);
    localparam int REMAP_DEPTH = 2 ** PIXEL_BITS;

    logic [MASK_W-1:0]     mask_mem [MASK_DEPTH];
    logic [PIXEL_BITS-1:0] remap_mem [REMAP_DEPTH];

    logic [MASK_W-1:0]     mask_rd_reg;
    logic [PIXEL_BITS-1:0] remap_rd_reg;
    logic [PIXEL_BITS-1:0] pixel_reg;
    logic [OFS_W-1:0]      ofs_reg;
    logic                  last_reg;
    logic [PIXEL_BITS-1:0] pix;

    assign pix = item.pixel_in[PIXEL_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_mask)
        begin
            mask_mem[item.table_index[MASK_AW-1:0]] <= item.table_value[MASK_W-1:0];
        end
        if (ctl.wr_remap)
        begin
            remap_mem[item.table_index[PIXEL_BITS-1:0]] <= item.table_value[PIXEL_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            mask_rd_reg  <= mask_mem[mask_addr];
            remap_rd_reg <= remap_mem[pix];
            pixel_reg    <= pix;
            ofs_reg      <= info.ofs;
            last_reg     <= info.last;
        end
    end

    assign res.ofs       = ofs_reg;
    assign res.last      = last_reg;
    assign res.mask_byte = mask_rd_reg;
    assign res.pixel     = PIX_W'(pixel_reg);
    assign res.remap     = PIX_W'(remap_rd_reg);
endmodule

// ===== design/scaled_mask_color_remap.sv =====
// scaled_mask_color_remap: top level of the scaled, masked color remap blit
// path: an accepted transaction waits in s0_reg; a pixel then passes the lookup read registers and the output register
// throughput: one transaction per cycle while rsp.ready holds, set by the single read port of each memory
// reset: control and walk state clear, registers take defaults (steps 1.0, others 0)
// mask store and remap table contents are undefined until written; no clearing pass
// depends on smcr_pkg, smcr_req_if, smcr_rsp_if, smcr_cfg_regs, smcr_walk, smcr_lookup
module scaled_mask_color_remap #(
    parameter int MASK_DEPTH = 4096,
    parameter int PIXEL_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [smcr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [smcr_pkg::CFG_DATA_W-1:0]  cfg_data,
    smcr_req_if.sink                         req,
    smcr_rsp_if.source                       rsp
);
    import smcr_pkg::*;

    localparam int MASK_AW = $clog2(MASK_DEPTH);

    cfg_t               cfg;
    walk_info_t         info;
    lookup_ctl_t        ctl;
    lookup_t            lk;
    logic [MASK_AW-1:0] mask_addr;

    logic      v0_reg, v0_next;
    in_item_t  s0_reg;
    logic      v1_reg, v1_next;
    logic      v2_reg, v2_next;
    out_item_t out_reg;
    out_item_t out_next;

    logic adv1;
    logic adv2;
    logic in_ready;
    logic nonempty;
    logic pix_go;

    // each stage moves when the one after it is empty or moving
    always_comb
    begin
        adv2     = !v2_reg || rsp.ready;
        adv1     = !v1_reg || adv2;
        in_ready = !v0_reg || adv1;
        nonempty = (cfg.rect_width != '0) && (cfg.rect_height != '0);
        pix_go   = v0_reg && adv1 && (s0_reg.req_type == REQ_PIXEL) && nonempty;
        ctl.wr_mask  = v0_reg && adv1 && (s0_reg.req_type == REQ_MASK);
        ctl.wr_remap = v0_reg && adv1 && (s0_reg.req_type == REQ_REMAP);
        ctl.rd       = pix_go;
    end

    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        v2_next = v2_reg;
        if (in_ready)
        begin
            v0_next = req.valid;
        end
        if (adv1)
        begin
            v1_next = pix_go;
        end
        if (adv2)
        begin
            v2_next = v1_reg;
        end
        out_next.dest_offset = lk.ofs;
        out_next.pixel_out   = (lk.mask_byte != '0) ? lk.remap : lk.pixel;
        out_next.last_pixel  = lk.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && req.valid)
        begin
            s0_reg <= req.data;
        end
        if (adv2 && v1_reg)
        begin
            out_reg <= out_next;
        end
    end

    smcr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    smcr_walk #(
        .MASK_AW (MASK_AW)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .restart   (cfg_we),
        .step      (pix_go),
        .mask_addr (mask_addr),
        .info      (info)
    );

    smcr_lookup #(
        .MASK_DEPTH (MASK_DEPTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_lookup (
        .clk       (clk),
        .ctl       (ctl),
        .item      (s0_reg),
        .mask_addr (mask_addr),
        .info      (info),
        .res       (lk)
    );

    assign req.ready = in_ready;
    assign rsp.valid = v2_reg;
    assign rsp.data  = out_reg;

    a_pixel_enters_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        pix_go |=> v1_reg)
        else $error("processed pixel did not reach the lookup stage");

    a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (v0_reg && v1_reg && v2_reg))
        else $error("request stalled with an empty stage");

    a_lookup_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && adv2) |=> v2_reg)
        else $error("lookup result lost on the way to the output register");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_mask || ctl.wr_remap) |=> !v1_reg)
        else $error("table write produced a result");
endmodule

// ===== bench/scaled_mask_color_remap_tb.sv =====
// scaled_mask_color_remap_tb: self-checking bench for the scaled mask color remap blit
// predicts every pixel transaction and compares results in order, with random idling
// depends on smcr_pkg, smcr_req_if, smcr_rsp_if and scaled_mask_color_remap
module scaled_mask_color_remap_tb;
    import smcr_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1200;
    localparam int EDGE_PIXELS  = 200;
    localparam int MASK_DEPTH   = 4096;
    localparam int MADDR_W      = 12;
    localparam int MAX_WAIT     = 16;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    smcr_req_if req ();
    smcr_rsp_if rsp ();

    scaled_mask_color_remap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp)
    );

    // register copy
    logic [DIM_W-1:0]   rect_w;
    logic [DIM_W-1:0]   rect_h;
    logic [STEP_W-1:0]  x_step;
    logic [STEP_W-1:0]  y_step;
    logic [DIM_W-1:0]   mask_pitch;
    logic [DIM_W-1:0]   dest_pitch;
    logic [DIM_W-1:0]   dest_x;
    logic [DIM_W-1:0]   dest_y;

    // walk state copy
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [ACC_W-1:0]   x_acc;
    logic [FRAC_W-1:0]  y_frac;
    logic [MADDR_W-1:0] mask_row;
    logic [OFS_W-1:0]   dest_row;

    logic [MASK_W-1:0]  mask_mem [MASK_DEPTH];
    bit                 mask_written [MASK_DEPTH];
    logic [PIX_W-1:0]   remap_mem [65536];
    bit                 remap_written [65536];

    out_item_t          expected_pixels [$];
    int                 error_count   = 0;
    int                 counted_items = 0;
    bit                 gaps_on       = 1'b1;
    int                 rsp_hold      = 0;
    int unsigned        cycle_count   = 0;

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.data  = '0;
        rsp.ready = 1'b0;
    end

    function automatic void restart_walk();
        col_pos  = 0;
        row_pos  = 0;
        x_acc    = '0;
        y_frac   = '0;
        mask_row = '0;
        dest_row = '0;
    endfunction

    function automatic void reset_model();
        rect_w     = '0;
        rect_h     = '0;
        x_step     = STEP_ONE;
        y_step     = STEP_ONE;
        mask_pitch = '0;
        dest_pitch = '0;
        dest_x     = '0;
        dest_y     = '0;
        restart_walk();
    endfunction

    function automatic logic [MADDR_W-1:0] next_mask_addr();
        logic [MADDR_W-1:0] addr;
        if (col_pos == 0 && row_pos == 0)
            addr = '0;
        else
            addr = mask_row + MADDR_W'(x_acc[ACC_W-1:FRAC_W]);
        return addr;
    endfunction

    // returns 1 when the transaction does something
    function automatic bit predict_blit(input in_item_t item);
        logic [31:0]        wide;
        logic [31:0]        prod;
        logic [MADDR_W-1:0] maddr;
        out_item_t          want;
        case (item.req_type)
            REQ_MASK:
            begin
                mask_mem[item.table_index[MADDR_W-1:0]]     = item.table_value[MASK_W-1:0];
                mask_written[item.table_index[MADDR_W-1:0]] = 1'b1;
                return 1'b1;
            end
            REQ_REMAP:
            begin
                remap_mem[item.table_index]     = item.table_value;
                remap_written[item.table_index] = 1'b1;
                return 1'b1;
            end
            REQ_PIXEL:
            begin
                if (rect_w == 0 || rect_h == 0)
                    return 1'b0;
                if (col_pos == 0 && row_pos == 0)
                begin
                    wide     = 32'(dest_y) * 32'(dest_pitch) + 32'(dest_x);
                    dest_row = wide[OFS_W-1:0];
                    mask_row = '0;
                    x_acc    = '0;
                    y_frac   = '0;
                end
                maddr            = mask_row + MADDR_W'(x_acc[ACC_W-1:FRAC_W]);
                want.pixel_out   = (mask_mem[maddr] != 0) ? remap_mem[item.pixel_in]
                                                          : item.pixel_in;
                want.dest_offset = dest_row + OFS_W'(col_pos);
                want.last_pixel  = 1'b0;
                x_acc            = x_acc + ACC_W'(x_step);
                col_pos++;
                if (col_pos >= rect_w)
                begin
                    col_pos  = 0;
                    x_acc    = '0;
                    dest_row = dest_row + OFS_W'(dest_pitch);
                    wide     = 32'(y_frac) + 32'(y_step);
                    prod     = 32'(wide[31:16]) * 32'(mask_pitch);
                    mask_row = mask_row + prod[MADDR_W-1:0];
                    y_frac   = wide[FRAC_W-1:0];
                    row_pos++;
                    if (row_pos >= rect_h)
                    begin
                        want.last_pixel = 1'b1;
                        restart_walk();
                    end
                end
                expected_pixels.push_back(want);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic in_item_t make_item(input logic [REQ_W-1:0] kind,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [PIX_W-1:0] val,
                                           input logic [PIX_W-1:0] pix);
        in_item_t item;
        item.req_type    = kind;
        item.table_index = idx;
        item.table_value = val;
        item.pixel_in    = pix;
        return item;
    endfunction

    function automatic logic [PIX_W-1:0] rand_mask_value();
        logic [PIX_W-1:0] v;
        v = PIX_W'($urandom);
        if ($urandom_range(0, 1) == 0)
            v[MASK_W-1:0] = '0;
        return v;
    endfunction

    task automatic send_req(input in_item_t item);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= item;
        @(posedge clk);
        while (req.ready !== 1'b1)
            @(posedge clk);
        if (predict_blit(item))
            counted_items++;
        @(negedge clk);
    endtask

    // loads the mask byte and remap entry the pixel will read if they were never written
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        logic [MADDR_W-1:0] addr;
        if (rect_w != 0 && rect_h != 0)
        begin
            addr = next_mask_addr();
            if (!mask_written[addr])
                send_req(make_item(REQ_MASK, {4'($urandom_range(0, 15)), addr},
                                   rand_mask_value(), 16'($urandom)));
            if (mask_mem[addr] != 0 && !remap_written[pix])
                send_req(make_item(REQ_REMAP, pix, 16'($urandom), 16'($urandom)));
        end
        send_req(make_item(REQ_PIXEL, 16'($urandom), 16'($urandom), pix));
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_RECT_WIDTH:  rect_w     = value[DIM_W-1:0];
            CFG_RECT_HEIGHT: rect_h     = value[DIM_W-1:0];
            CFG_X_STEP:      x_step     = value;
            CFG_Y_STEP:      y_step     = value;
            CFG_MASK_PITCH:  mask_pitch = value[DIM_W-1:0];
            CFG_DEST_PITCH:  dest_pitch = value[DIM_W-1:0];
            CFG_DEST_X:      dest_x     = value[DIM_W-1:0];
            default:         dest_y     = value[DIM_W-1:0];
        endcase
        restart_walk();
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_reg_value(input cfg_index_e idx);
        logic [CFG_DATA_W-1:0] v;
        v = CFG_DATA_W'($urandom);
        case (idx)
            CFG_RECT_WIDTH, CFG_RECT_HEIGHT:
            begin
                case ($urandom_range(0, 9))
                    0:       v[DIM_W-1:0] = '0;
                    1:       v[DIM_W-1:0] = DIM_W'($urandom_range(9, 40));
                    default: v[DIM_W-1:0] = DIM_W'($urandom_range(1, 8));
                endcase
            end
            CFG_X_STEP, CFG_Y_STEP:
            begin
                case ($urandom_range(0, 5))
                    0:       v = '0;
                    1:       v = STEP_ONE;
                    2:       v = '1;
                    3:       v = CFG_DATA_W'($urandom_range(0, 24'h3ffff));
                    default: ;
                endcase
            end
            CFG_MASK_PITCH:
                if ($urandom_range(0, 1) == 0)
                    v[DIM_W-1:0] = DIM_W'($urandom_range(0, 16));
            default: ;
        endcase
        // stray bits above the register width now and then
        if (idx != CFG_X_STEP && idx != CFG_Y_STEP && $urandom_range(0, 3) != 0)
            v[CFG_DATA_W-1:DIM_W] = '0;
        return v;
    endfunction

    task automatic test_empty_rect();
        wait_idle();
        send_pixel(16'h1234);
        wait_idle();
        write_reg(CFG_RECT_WIDTH, 24'd1);
        send_pixel(16'habcd);
        wait_idle();
        write_reg(CFG_RECT_HEIGHT, 24'd3);
        repeat (3) send_pixel(16'($urandom));
        wait_idle();
        write_reg(CFG_RECT_WIDTH, 24'd0);
        send_pixel(16'h0f0f);
    endtask

    task automatic test_ignored_request();
        wait_idle();
        write_reg(CFG_RECT_WIDTH, 24'd2);
        send_req(make_item(REQ_UNUSED, '1, '1, '1));
        send_pixel(16'h5a5a);
        send_req(make_item(REQ_UNUSED, '0, '0, '0));
        send_pixel(16'ha5a5);
    endtask

    task automatic test_field_extremes();
        wait_idle();
        write_reg(CFG_RECT_WIDTH, 24'hfff002);
        write_reg(CFG_RECT_HEIGHT, 24'd2);
        write_reg(CFG_X_STEP, 24'hffffff);
        write_reg(CFG_Y_STEP, 24'hffffff);
        write_reg(CFG_MASK_PITCH, 24'hfff);
        write_reg(CFG_DEST_PITCH, 24'hfff);
        write_reg(CFG_DEST_X, 24'hfff);
        write_reg(CFG_DEST_Y, 24'hfff);
        send_req(make_item(REQ_MASK, 16'hffff, 16'hffff, 16'h0000));
        send_req(make_item(REQ_MASK, 16'h0000, 16'hff00, 16'hffff));
        send_req(make_item(REQ_REMAP, 16'hffff, 16'hffff, 16'h0000));
        send_req(make_item(REQ_REMAP, 16'h0000, 16'h0000, 16'hffff));
        send_pixel(16'hffff);
        send_pixel(16'h0000);
        send_pixel(16'hffff);
        send_pixel(16'h0000);
        wait_idle();
        write_reg(CFG_X_STEP, 24'd0);
        send_req(make_item(REQ_MASK, 16'hf000, 16'h0001, 16'h0000));
        send_pixel(16'hffff);
        send_pixel(16'h0000);
        send_req(make_item(REQ_MASK, 16'h1000, 16'h0080, 16'h0000));
        send_pixel(16'h0000);
        send_pixel(16'hffff);
    endtask

    task automatic test_random_walks();
        int          n;
        int          kind;
        cfg_index_e  idx;
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS)
        begin
            wait_idle();
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 0)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    idx = cfg_index_e'(i);
                    write_reg(idx, rand_reg_value(idx));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    idx = cfg_index_e'($urandom_range(0, 7));
                    write_reg(idx, rand_reg_value(idx));
                end
            end
            n = $urandom_range(20, 80);
            repeat (n)
            begin
                kind = $urandom_range(0, 19);
                case (kind)
                    0, 1:
                        send_req(make_item(REQ_MASK, 16'($urandom), rand_mask_value(),
                                           16'($urandom)));
                    2:
                        send_req(make_item(REQ_MASK,
                                           {4'($urandom_range(0, 15)), next_mask_addr()},
                                           rand_mask_value(), 16'($urandom)));
                    3, 4:
                        send_req(make_item(REQ_REMAP, 16'($urandom), 16'($urandom),
                                           16'($urandom)));
                    5:
                        send_req(make_item(REQ_UNUSED, 16'($urandom), 16'($urandom),
                                           16'($urandom)));
                    default:
                        send_pixel(16'($urandom));
                endcase
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_wide_rect();
        wait_idle();
        gaps_on = 1'b0;
        write_reg(CFG_RECT_WIDTH, 24'hfff);
        write_reg(CFG_RECT_HEIGHT, 24'd1);
        write_reg(CFG_X_STEP, 24'h008000);
        write_reg(CFG_DEST_PITCH, 24'd17);
        write_reg(CFG_DEST_X, 24'd3);
        write_reg(CFG_DEST_Y, 24'd2);
        repeat (EDGE_PIXELS) send_pixel(16'($urandom));
        gaps_on = 1'b1;
    endtask

    task automatic test_tall_rect();
        wait_idle();
        gaps_on = 1'b0;
        write_reg(CFG_RECT_WIDTH, 24'd1);
        write_reg(CFG_RECT_HEIGHT, 24'hfff);
        write_reg(CFG_Y_STEP, 24'h008000);
        write_reg(CFG_MASK_PITCH, 24'd3);
        write_reg(CFG_DEST_PITCH, 24'hfff);
        repeat (EDGE_PIXELS) send_pixel(16'($urandom));
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            got = rsp.data;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none, actual %h %h %b",
                         $time, got.dest_offset, got.pixel_out, got.last_pixel);
                error_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.dest_offset !== want.dest_offset)
                begin
                    $display("%0t dest_offset mismatch: expected %h actual %h",
                             $time, want.dest_offset, got.dest_offset);
                    error_count++;
                end
                if (got.pixel_out !== want.pixel_out)
                begin
                    $display("%0t pixel_out mismatch: expected %h actual %h",
                             $time, want.pixel_out, got.pixel_out);
                    error_count++;
                end
                if (got.last_pixel !== want.last_pixel)
                begin
                    $display("%0t last_pixel mismatch: expected %b actual %b",
                             $time, want.last_pixel, got.last_pixel);
                    error_count++;
                end
            end
            rsp_hold = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
        end
    end

    always @(negedge clk)
    begin
        if (rsp_hold > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_hold--;
        end
        else
            rsp.ready <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        reset_model();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_rect();
        test_ignored_request();
        test_field_extremes();
        test_random_walks();
        test_wide_rect();
        test_tall_rect();
        wait_idle();
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
